// ===== src/cta_pkg.sv =====
// shared types and constants of the cooldown task arbiter
// used by every module of the block, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cta_pkg;

	localparam int NUM_CLASSES = 26;
	localparam int COUNT_W     = 16;
	localparam int CLS_W       = 5;
	localparam int IDX_W       = $clog2(NUM_CLASSES);
	localparam int TMR_W       = 11;
	localparam int CFG_W       = 10;
	localparam int TOT_W       = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int GRP         = 8;
	localparam int NUM_GRP     = (NUM_CLASSES + GRP - 1) / GRP;

	localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};
	localparam logic [TMR_W-1:0]   TMR_MAX = {TMR_W{1'b1}};
	localparam logic [TOT_W-1:0]   TOT_MAX = {TOT_W{1'b1}};

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [CLS_W-1:0] class_id;
	} cmd_t;

	typedef struct packed {
		logic             granted;
		logic [CLS_W-1:0] granted_class;
		logic             all_done;
		logic [TOT_W-1:0] elapsed_ticks;
		logic             add_overflow;
	} rsp_t;

	typedef struct packed {
		logic             is_tick;
		logic             cls_ok;
		logic [IDX_W-1:0] idx;
	} item_t;

endpackage

`default_nettype wire

// ===== src/cta_front.sv =====
// front end: accepts commands and classifies them into queue items
// depends on cta_pkg
`timescale 1ns / 1ps
`default_nettype none

module cta_front (
	input  wire               start,
	input  cta_pkg::cmd_t     cmd,
	input  wire               q_full,
	output logic              busy,
	output logic              push,
	output cta_pkg::item_t    item
);

	assign busy = q_full;
	assign push = start && !q_full;

	always_comb begin
		item.is_tick = (cmd.operation == cta_pkg::OP_TICK);
		item.cls_ok  = (32'(cmd.class_id) < cta_pkg::NUM_CLASSES);
		item.idx     = cta_pkg::IDX_W'(cmd.class_id);
	end

endmodule

`default_nettype wire

// ===== src/cta_queue.sv =====
// short item queue between front and back end
// depends on cta_pkg
`timescale 1ns / 1ps
`default_nettype none

module cta_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  cta_pkg::item_t  push_item,
	input  wire             pop,
	output logic            full,
	output logic            empty,
	output cta_pkg::item_t  head
);

	localparam int PTR_W = (cta_pkg::QUEUE_DEPTH > 1) ? $clog2(cta_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(cta_pkg::QUEUE_DEPTH + 1);

	cta_pkg::item_t   mem_q [cta_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(cta_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(cta_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(cta_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/cta_back.sv =====
// back end: per-class counts and cooldown timers, grant search, result register
// depends on cta_pkg
`timescale 1ns / 1ps
`default_nettype none

module cta_back (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire [cta_pkg::CFG_W-1:0]    cooldown,
	input  wire                         q_empty,
	input  cta_pkg::item_t              q_head,
	output logic                        pop,
	output logic                        rsp_valid,
	output cta_pkg::rsp_t               rsp
);

	localparam int N = cta_pkg::NUM_CLASSES;
	localparam int G = cta_pkg::NUM_GRP;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_SRCH1 = 2'd2;
	localparam logic [1:0] S_SRCH2 = 2'd3;

	logic [1:0]                   state_q;
	cta_pkg::item_t               item_q;
	logic [cta_pkg::COUNT_W-1:0]  cnt_q [N];
	logic                         cool_q [N];
	logic [cta_pkg::TMR_W-1:0]    tmr_q [N];
	logic [cta_pkg::TOT_W-1:0]    tot_q;
	logic [cta_pkg::COUNT_W-1:0]  grp_cnt_s1 [G];
	logic [cta_pkg::IDX_W-1:0]    grp_idx_s1 [G];
	logic                         rsp_valid_q;
	cta_pkg::rsp_t                rsp_q;

	logic                         any_pend;
	logic                         add_ovf;
	logic [cta_pkg::COUNT_W-1:0]  key [N];
	logic                         cool_nx [N];
	logic [cta_pkg::TMR_W-1:0]    tmr_nx [N];
	logic [cta_pkg::COUNT_W-1:0]  grp_cnt [G];
	logic [cta_pkg::IDX_W-1:0]    grp_idx [G];
	logic [cta_pkg::COUNT_W-1:0]  best_cnt;
	logic [cta_pkg::IDX_W-1:0]    best_idx;

	assign pop       = (state_q == S_IDLE) && !q_empty;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign add_ovf   = item_q.cls_ok && (cnt_q[item_q.idx] == cta_pkg::CNT_MAX);

	// pending flag, eligibility keys and timer advance
	always_comb begin
		logic [cta_pkg::TMR_W-1:0] t;
		any_pend = 1'b0;
		for (int i = 0; i < N; i++) begin
			any_pend = any_pend || (cnt_q[i] != '0);
			key[i]   = (cnt_q[i] != '0 && !cool_q[i]) ? cnt_q[i] : '0;
			t        = (cool_q[i] && tmr_q[i] != cta_pkg::TMR_MAX) ? tmr_q[i] + 1'b1 : tmr_q[i];
			if (t > {1'b0, cooldown}) begin
				cool_nx[i] = 1'b0;
				tmr_nx[i]  = '0;
			end else begin
				cool_nx[i] = cool_q[i];
				tmr_nx[i]  = t;
			end
		end
	end

	// first search level: best of each group, lowest index on ties
	always_comb begin
		int k;
		k = 0;
		for (int g = 0; g < G; g++) begin
			grp_cnt[g] = '0;
			grp_idx[g] = cta_pkg::IDX_W'(g * cta_pkg::GRP);
			for (int j = 0; j < cta_pkg::GRP; j++) begin
				k = g * cta_pkg::GRP + j;
				if (k < N) begin
					if (key[k] > grp_cnt[g]) begin
						grp_cnt[g] = key[k];
						grp_idx[g] = cta_pkg::IDX_W'(k);
					end
				end
			end
		end
	end

	// second search level over group winners
	always_comb begin
		best_cnt = '0;
		best_idx = grp_idx_s1[0];
		for (int g = 0; g < G; g++) begin
			if (grp_cnt_s1[g] > best_cnt) begin
				best_cnt = grp_cnt_s1[g];
				best_idx = grp_idx_s1[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_head;
		end
		if (state_q == S_SRCH1) begin
			for (int g = 0; g < G; g++) begin
				grp_cnt_s1[g] <= grp_cnt[g];
				grp_idx_s1[g] <= grp_idx[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tot_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			for (int i = 0; i < N; i++) begin
				cnt_q[i]  <= '0;
				cool_q[i] <= 1'b0;
				tmr_q[i]  <= '0;
			end
		end else begin
			rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (!item_q.is_tick) begin
						if (item_q.cls_ok && !add_ovf) begin
							cnt_q[item_q.idx] <= cnt_q[item_q.idx] + 1'b1;
						end
						rsp_valid_q         <= 1'b1;
						rsp_q.granted       <= 1'b0;
						rsp_q.granted_class <= '0;
						rsp_q.all_done      <= !(any_pend || item_q.cls_ok);
						rsp_q.elapsed_ticks <= tot_q;
						rsp_q.add_overflow  <= add_ovf;
						state_q             <= S_IDLE;
					end else if (!any_pend) begin
						rsp_valid_q         <= 1'b1;
						rsp_q.granted       <= 1'b0;
						rsp_q.granted_class <= '0;
						rsp_q.all_done      <= 1'b1;
						rsp_q.elapsed_ticks <= tot_q;
						rsp_q.add_overflow  <= 1'b0;
						state_q             <= S_IDLE;
					end else begin
						if (tot_q != cta_pkg::TOT_MAX) begin
							tot_q <= tot_q + 1'b1;
						end
						for (int i = 0; i < N; i++) begin
							cool_q[i] <= cool_nx[i];
							tmr_q[i]  <= tmr_nx[i];
						end
						state_q <= S_SRCH1;
					end
				end
				S_SRCH1: begin
					state_q <= S_SRCH2;
				end
				S_SRCH2: begin
					if (best_cnt != '0) begin
						cnt_q[best_idx]  <= cnt_q[best_idx] - 1'b1;
						cool_q[best_idx] <= 1'b1;
						tmr_q[best_idx]  <= '0;
					end
					rsp_valid_q         <= 1'b1;
					rsp_q.granted       <= (best_cnt != '0);
					rsp_q.granted_class <= (best_cnt != '0) ? cta_pkg::CLS_W'(best_idx) : '0;
					rsp_q.all_done      <= 1'b0;
					rsp_q.elapsed_ticks <= tot_q;
					rsp_q.add_overflow  <= 1'b0;
					state_q             <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/cooldown_task_arbiter_core.sv =====
// top level of the cooldown task arbiter: front end, item queue, back end
// and the cooldown register; depends on cta_pkg, cta_front, cta_queue, cta_back
//
// usage
//   command channel: a transaction is taken at a rising edge with start high and
//   busy low; cmd.operation selects add (one task of cmd.class_id) or tick.
//   busy is high while the two-entry item queue is full.
//   result channel: every command gives exactly one result on rsp, shown for
//   one cycle with rsp_valid high; the receiver cannot stall it.
//   config channel: cfg_data (cooldown ticks) is written when cfg_valid is
//   high; cfg_ready is always high. write only while the block is idle.
// processing
//   an add passes the back end through pop and execute, a tick with pending
//   work through pop, timer update, group search, final search and grant; the
//   two-level search over the class counts sets the tick length. commands
//   queue up behind the back end, one in process at a time.
// reset
//   arst_n clears all counts, cooldown state, the elapsed counter, the queue
//   and the cooldown register; the block is ready in the first cycle after.
`timescale 1ns / 1ps
`default_nettype none

module cooldown_task_arbiter_core (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  cta_pkg::cmd_t               cmd,
	output logic                        rsp_valid,
	output cta_pkg::rsp_t               rsp,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire [cta_pkg::CFG_W-1:0]    cfg_data
);

	logic [cta_pkg::CFG_W-1:0] cfg_q;
	logic                      q_full;
	logic                      q_empty;
	logic                      push;
	logic                      pop;
	cta_pkg::item_t            push_item;
	cta_pkg::item_t            q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	cta_front u_front (
		.start  (start),
		.cmd    (cmd),
		.q_full (q_full),
		.busy   (busy),
		.push   (push),
		.item   (push_item)
	);

	cta_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	cta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cooldown  (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	a_idle_class_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.granted |-> rsp.granted_class == '0)
		else $error("class reported without a grant");

	a_grant_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.granted |-> !rsp.all_done && !rsp.add_overflow)
		else $error("grant with done or overflow flag");

	a_grant_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.granted |-> 32'(rsp.granted_class) < cta_pkg::NUM_CLASSES)
		else $error("granted class out of range");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== tb/tb_cooldown_task_arbiter_core.sv =====
// testbench for cooldown_task_arbiter_core: directed and random command
// streams checked against a cycle-free scoreboard of the grant and cooldown behavior
// depends on cta_pkg and the cooldown_task_arbiter_core rtl
`timescale 1ns / 1ps

module tb_cooldown_task_arbiter_core;

	localparam int IDLE_LIMIT = 2000;

	class cta_scoreboard;
		logic [cta_pkg::COUNT_W-1:0] task_cnt [cta_pkg::NUM_CLASSES];
		bit                          cooling  [cta_pkg::NUM_CLASSES];
		logic [cta_pkg::TMR_W-1:0]   cool_tmr [cta_pkg::NUM_CLASSES];
		logic [cta_pkg::TOT_W-1:0]   ticks_seen;
		logic [cta_pkg::CFG_W-1:0]   cooldown;
		cta_pkg::rsp_t               rsp_expected [$];
		int                          errors;

		function new();
			ticks_seen = '0;
			cooldown   = '0;
			errors     = 0;
			foreach (task_cnt[i]) begin
				task_cnt[i] = '0;
				cooling[i]  = 1'b0;
				cool_tmr[i] = '0;
			end
		endfunction

		function bit work_pending();
			foreach (task_cnt[i])
				if (task_cnt[i] != '0)
					return 1'b1;
			return 1'b0;
		endfunction

		function cta_pkg::rsp_t schedule_step(cta_pkg::cmd_t c);
			cta_pkg::rsp_t r;
			int            best;
			r    = '0;
			best = -1;
			if (c.operation == cta_pkg::OP_ADD) begin
				if (c.class_id < cta_pkg::NUM_CLASSES) begin
					if (task_cnt[c.class_id] == cta_pkg::CNT_MAX)
						r.add_overflow = 1'b1;
					else
						task_cnt[c.class_id] = task_cnt[c.class_id] + 1'b1;
				end
				r.all_done = !work_pending();
			end else if (!work_pending()) begin
				r.all_done = 1'b1;
			end else begin
				if (ticks_seen != cta_pkg::TOT_MAX)
					ticks_seen = ticks_seen + 1'b1;
				for (int i = 0; i < cta_pkg::NUM_CLASSES; i++) begin
					if (cooling[i] && cool_tmr[i] != cta_pkg::TMR_MAX)
						cool_tmr[i] = cool_tmr[i] + 1'b1;
					if (cool_tmr[i] > cooldown) begin
						cooling[i]  = 1'b0;
						cool_tmr[i] = '0;
					end
				end
				// strict compare keeps the lowest index on ties
				for (int i = 0; i < cta_pkg::NUM_CLASSES; i++)
					if (task_cnt[i] != '0 && !cooling[i] &&
					    (best < 0 || task_cnt[i] > task_cnt[best]))
						best = i;
				if (best >= 0) begin
					task_cnt[best] = task_cnt[best] - 1'b1;
					cooling[best]  = 1'b1;
					cool_tmr[best] = '0;
					r.granted       = 1'b1;
					r.granted_class = cta_pkg::CLS_W'(best);
				end
			end
			r.elapsed_ticks = ticks_seen;
			return r;
		endfunction

		function void note_cmd(cta_pkg::cmd_t c);
			rsp_expected.push_back(schedule_step(c));
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("%0t mismatch: %s", $realtime, msg);
		endtask

		task check_rsp(cta_pkg::rsp_t got);
			cta_pkg::rsp_t exp;
			if (rsp_expected.size() == 0) begin
				report("result with no command outstanding");
				return;
			end
			exp = rsp_expected.pop_front();
			if (got.granted !== exp.granted)
				report($sformatf("granted %0b, want %0b", got.granted, exp.granted));
			if (got.granted_class !== exp.granted_class)
				report($sformatf("granted_class %0d, want %0d",
					got.granted_class, exp.granted_class));
			if (got.all_done !== exp.all_done)
				report($sformatf("all_done %0b, want %0b", got.all_done, exp.all_done));
			if (got.elapsed_ticks !== exp.elapsed_ticks)
				report($sformatf("elapsed_ticks %0d, want %0d",
					got.elapsed_ticks, exp.elapsed_ticks));
			if (got.add_overflow !== exp.add_overflow)
				report($sformatf("add_overflow %0b, want %0b",
					got.add_overflow, exp.add_overflow));
		endtask
	endclass

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      start     = 1'b0;
	logic                      busy;
	cta_pkg::cmd_t             cmd       = '0;
	logic                      rsp_valid;
	cta_pkg::rsp_t             rsp;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [cta_pkg::CFG_W-1:0] cfg_data  = '0;

	cta_scoreboard sb = new();
	bit            burst = 1'b0;
	int            idle_cycles = 0;

	cooldown_task_arbiter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid)
			sb.check_rsp(rsp);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || rsp_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_cmd(input logic op, input logic [cta_pkg::CLS_W-1:0] cls);
		cta_pkg::cmd_t c;
		int            gap;
		c.operation = op;
		c.class_id  = cls;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		sb.note_cmd(c);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (sb.rsp_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_cooldown(input logic [cta_pkg::CFG_W-1:0] v);
		wait_drained();
		repeat ($urandom_range(0, 3)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.cooldown = v;
	endtask

	task automatic drain_work();
		while (sb.work_pending())
			send_cmd(cta_pkg::OP_TICK, cta_pkg::CLS_W'($urandom_range(0, 31)));
		send_cmd(cta_pkg::OP_TICK, cta_pkg::CLS_W'($urandom_range(0, 31)));
		send_cmd(cta_pkg::OP_TICK, cta_pkg::CLS_W'($urandom_range(0, 31)));
	endtask

	task automatic run_phase(input int n_items);
		int                        hot_a;
		int                        hot_b;
		int                        tick_pct;
		int                        r;
		logic                      op;
		logic [cta_pkg::CLS_W-1:0] cls;
		hot_a    = $urandom_range(0, cta_pkg::NUM_CLASSES - 1);
		hot_b    = $urandom_range(0, cta_pkg::NUM_CLASSES - 1);
		tick_pct = $urandom_range(30, 60);
		for (int k = 0; k < n_items; k++) begin
			if (k % 40 == 0)
				burst = ($urandom_range(0, 3) == 0);
			op = ($urandom_range(0, 99) < tick_pct) ? cta_pkg::OP_TICK : cta_pkg::OP_ADD;
			r  = $urandom_range(0, 99);
			if (r < 30)
				cls = cta_pkg::CLS_W'(hot_a);
			else if (r < 50)
				cls = cta_pkg::CLS_W'(hot_b);
			else if (r < 92)
				cls = cta_pkg::CLS_W'($urandom_range(0, cta_pkg::NUM_CLASSES - 1));
			else
				cls = cta_pkg::CLS_W'($urandom_range(cta_pkg::NUM_CLASSES, 31));
			send_cmd(op, cls);
		end
		burst = 1'b0;
	endtask

	initial begin
		int                        phase_cd [8];
		logic [cta_pkg::CLS_W-1:0] tail_cls;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// cooldown at its reset value of zero
		send_cmd(cta_pkg::OP_TICK, 5'd31);
		send_cmd(cta_pkg::OP_ADD, 5'd31);
		send_cmd(cta_pkg::OP_ADD, 5'd26);
		send_cmd(cta_pkg::OP_ADD, 5'd0);
		send_cmd(cta_pkg::OP_ADD, 5'd25);
		send_cmd(cta_pkg::OP_ADD, 5'd25);
		send_cmd(cta_pkg::OP_TICK, 5'd0);
		send_cmd(cta_pkg::OP_TICK, 5'd0);
		send_cmd(cta_pkg::OP_TICK, 5'd21);
		send_cmd(cta_pkg::OP_TICK, 5'd10);

		// longest cooldown: classes stay blocked, ticks go idle
		write_cooldown(10'd1023);
		send_cmd(cta_pkg::OP_ADD, 5'd5);
		send_cmd(cta_pkg::OP_ADD, 5'd5);
		send_cmd(cta_pkg::OP_ADD, 5'd7);
		send_cmd(cta_pkg::OP_ADD, 5'd16);
		send_cmd(cta_pkg::OP_ADD, 5'd8);
		send_cmd(cta_pkg::OP_TICK, 5'd0);
		send_cmd(cta_pkg::OP_TICK, 5'd0);
		send_cmd(cta_pkg::OP_TICK, 5'd0);
		send_cmd(cta_pkg::OP_TICK, 5'd0);
		send_cmd(cta_pkg::OP_TICK, 5'd0);
		send_cmd(cta_pkg::OP_TICK, 5'd0);

		phase_cd = '{3, 1023, 0, $urandom_range(0, 15), 700, 1,
			$urandom_range(0, 1023), 0};
		foreach (phase_cd[p]) begin
			write_cooldown(cta_pkg::CFG_W'(phase_cd[p]));
			run_phase(125);
			if (phase_cd[p] <= 3)
				drain_work();
		end

		// short tail with a fresh cooldown
		write_cooldown(cta_pkg::CFG_W'($urandom_range(0, 2)));
		tail_cls = cta_pkg::CLS_W'($urandom_range(0, cta_pkg::NUM_CLASSES - 1));
		send_cmd(cta_pkg::OP_ADD,
			cta_pkg::CLS_W'($urandom_range(0, cta_pkg::NUM_CLASSES - 1)));
		repeat (4) send_cmd(cta_pkg::OP_TICK, cta_pkg::CLS_W'($urandom_range(0, 31)));
		send_cmd(cta_pkg::OP_ADD, tail_cls);
		send_cmd(cta_pkg::OP_ADD, tail_cls);

		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.rsp_expected.size() != 0)
			sb.report("results still outstanding at end of run");
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
src/cta_pkg.sv
src/cta_front.sv
src/cta_queue.sv
src/cta_back.sv
src/cooldown_task_arbiter_core.sv
tb/tb_cooldown_task_arbiter_core.sv
